>>> sv/cee_pkg.sv
// Shared types, constants and helper functions for the calorimeter entry
// extrapolation unit. No dependencies; every other file imports this package.
`default_nettype none

package cee_pkg;

  localparam int COORD_W   = 21;
  localparam int MOM_W     = 24;
  localparam int CFG_W     = 20;
  localparam int CFG_IDX_W = 1;
  localparam int STAT_W    = 3;
  localparam int HIT_W     = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_ENDCAP_Z = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BARREL_R = 1'b1;

  localparam logic [CFG_W-1:0] ENDCAP_Z_RST = 20'd156800;
  localparam logic [CFG_W-1:0] BARREL_R_RST = 20'd137600;

  localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
  localparam logic [STAT_W-1:0] ST_PZ0     = 3'd1;
  localparam logic [STAT_W-1:0] ST_BEYOND  = 3'd2;
  localparam logic [STAT_W-1:0] ST_PT0     = 3'd3;
  localparam logic [STAT_W-1:0] ST_OUTSIDE = 3'd4;

  localparam logic RG_ENDCAP = 1'b0;
  localparam logic RG_BARREL = 1'b1;

  // Divider: numerator, divisor and quotient widths. Quotients at or above
  // 2^DIV_QW are detected up front and clamp to the offset limit.
  localparam int DIV_NW  = 88;
  localparam int DIV_DW  = 64;
  localparam int DIV_QW  = 23;
  localparam int DIV_LAT = DIV_QW + 2;
  localparam logic [DIV_QW-1:0] MAG_LIMIT = 23'h400000;

  // Square root of D * 2^32, D below 2^90.
  localparam int D_W    = 90;
  localparam int SQ_W   = 61;
  localparam int SQ_LAT = SQ_W + 1;
  localparam int M_W    = 62;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  localparam logic signed [HIT_W-1:0] HIT_MAXC = 24'sd1048575;
  localparam logic signed [HIT_W-1:0] HIT_MINC = -24'sd1048576;

  typedef struct packed {
    logic signed [COORD_W-1:0] rx;
    logic signed [COORD_W-1:0] ry;
    logic signed [COORD_W-1:0] rz;
    logic signed [MOM_W-1:0]   px;
    logic signed [MOM_W-1:0]   py;
    logic signed [MOM_W-1:0]   pz;
    logic signed [COORD_W-1:0] zp;
    logic [21:0]               dzm;
    logic                      negx;
    logic                      negy;
    logic [STAT_W-1:0]         status;
    logic                      region;
    logic signed [HIT_W-1:0]   hx;
    logic signed [HIT_W-1:0]   hy;
    logic [47:0]               a;
    logic signed [45:0]        b;
  } trk_t;

  function automatic logic [20:0] mag21(input logic signed [20:0] v);
    mag21 = v[20] ? 21'(-v) : 21'(v);
  endfunction

  function automatic logic [23:0] mag24(input logic signed [23:0] v);
    mag24 = v[23] ? 24'(-v) : 24'(v);
  endfunction

  function automatic logic [45:0] mag46(input logic signed [45:0] v);
    mag46 = v[45] ? 46'(-v) : 46'(v);
  endfunction

  function automatic logic signed [HIT_W-1:0] offs(input logic signed [COORD_W-1:0] base,
                                                   input logic neg,
                                                   input logic [DIV_QW-1:0] q);
    logic signed [HIT_W-1:0] bb;
    logic signed [HIT_W-1:0] mm;
    bb = HIT_W'(base);
    mm = $signed({1'b0, q});
    offs = neg ? bb - mm : bb + mm;
  endfunction

  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [HIT_W-1:0] v);
    if (v > HIT_MAXC) begin
      sat_coord = HIT_MAXC[COORD_W-1:0];
    end else if (v < HIT_MINC) begin
      sat_coord = HIT_MINC[COORD_W-1:0];
    end else begin
      sat_coord = v[COORD_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

>>> sv/cee_div.sv
// Pipelined restoring divider with round-to-nearest and offset clamp.
// One quotient bit per stage; depends on cee_pkg.
`default_nettype none

module cee_div import cee_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [DIV_NW-1:0] num,
  input  logic [DIV_DW-1:0] den,
  output logic [DIV_QW-1:0] quo
);

  logic [DIV_DW-1:0] rem [DIV_QW+1];
  logic [DIV_DW-1:0] dv  [DIV_QW+1];
  logic [DIV_QW-1:0] qv  [DIV_QW+1];
  logic [DIV_QW-1:0] nl  [DIV_QW+1];
  logic [DIV_QW:0]   ovf;

  logic [DIV_DW-1:0] rem_n [DIV_QW+1];
  logic              qb_n  [DIV_QW+1];
  logic [DIV_DW:0]   trial [DIV_QW+1];
  logic [DIV_QW:0]   qr;
  logic              rnd;

  always_comb begin
    rem_n[0] = '0;
    qb_n[0]  = 1'b0;
    trial[0] = '0;
    for (int k = 1; k <= DIV_QW; k++) begin
      trial[k] = {rem[k-1], nl[k-1][DIV_QW-1]};
      if (trial[k] >= {1'b0, dv[k-1]}) begin
        qb_n[k]  = 1'b1;
        rem_n[k] = trial[k][DIV_DW-1:0] - dv[k-1];
      end else begin
        qb_n[k]  = 1'b0;
        rem_n[k] = trial[k][DIV_DW-1:0];
      end
    end
  end

  // Ties round up on the magnitude.
  assign rnd = {rem[DIV_QW], 1'b0} >= {1'b0, dv[DIV_QW]};
  assign qr  = {1'b0, qv[DIV_QW]} + (DIV_QW+1)'(rnd);

  always_ff @(posedge clk) begin
    if (en) begin
      ovf[0] <= num >= {1'b0, den, {DIV_QW{1'b0}}};
      rem[0] <= num[DIV_QW+DIV_DW-1:DIV_QW];
      dv[0]  <= den;
      qv[0]  <= '0;
      nl[0]  <= num[DIV_QW-1:0];
      for (int k = 1; k <= DIV_QW; k++) begin
        ovf[k] <= ovf[k-1];
        rem[k] <= rem_n[k];
        dv[k]  <= dv[k-1];
        qv[k]  <= {qv[k-1][DIV_QW-2:0], qb_n[k]};
        nl[k]  <= {nl[k-1][DIV_QW-2:0], 1'b0};
      end
      if (ovf[DIV_QW] || qr > {1'b0, MAG_LIMIT}) begin
        quo <= MAG_LIMIT;
      end else begin
        quo <= qr[DIV_QW-1:0];
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/cee_sqrt.sv
// Pipelined integer square root, two radicand bits per stage.
// Depends on cee_pkg.
`default_nettype none

module cee_sqrt import cee_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [2*SQ_W-1:0] rad,
  output logic [SQ_W-1:0]   root
);

  logic [2*SQ_W-1:0] rs  [SQ_W+1];
  logic [SQ_W+1:0]   rem [SQ_W+1];
  logic [SQ_W-1:0]   rt  [SQ_W+1];

  logic [SQ_W+1:0] tv    [SQ_W+1];
  logic [SQ_W+1:0] trial [SQ_W+1];
  logic [SQ_W+1:0] rem_n [SQ_W+1];
  logic            rb_n  [SQ_W+1];

  always_comb begin
    tv[0]    = '0;
    trial[0] = '0;
    rem_n[0] = '0;
    rb_n[0]  = 1'b0;
    for (int k = 1; k <= SQ_W; k++) begin
      tv[k]    = {rem[k-1][SQ_W-1:0], rs[k-1][2*SQ_W-1:2*SQ_W-2]};
      trial[k] = {rt[k-1], 2'b01};
      if (tv[k] >= trial[k]) begin
        rb_n[k]  = 1'b1;
        rem_n[k] = tv[k] - trial[k];
      end else begin
        rb_n[k]  = 1'b0;
        rem_n[k] = tv[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rs[0]  <= rad;
      rem[0] <= '0;
      rt[0]  <= '0;
      for (int k = 1; k <= SQ_W; k++) begin
        rs[k]  <= {rs[k-1][2*SQ_W-3:0], 2'b00};
        rem[k] <= rem_n[k];
        rt[k]  <= {rt[k-1][SQ_W-2:0], rb_n[k]};
      end
    end
  end

  assign root = rt[SQ_W];

endmodule

`default_nettype wire

>>> sv/cee_front.sv
// Front end: takes input beats, classifies the track (status, endcap side,
// path direction) and hands it to the queue. Depends on cee_pkg.
`default_nettype none

module cee_front import cee_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [COORD_W-1:0] ref_x,
  input  logic signed [COORD_W-1:0] ref_y,
  input  logic signed [COORD_W-1:0] ref_z,
  input  logic signed [MOM_W-1:0]   mom_x,
  input  logic signed [MOM_W-1:0]   mom_y,
  input  logic signed [MOM_W-1:0]   mom_z,
  input  logic [CFG_W-1:0]          endcap_z,
  input  logic                      q_full,
  output logic                      push,
  output trk_t                      item
);

  logic                      fv;
  trk_t                      fitem;
  trk_t                      cls;
  logic signed [COORD_W-1:0] zc;
  logic signed [COORD_W-1:0] zp;
  logic signed [21:0]        dz;
  logic                      sgn;

  always_comb begin
    zc  = $signed({1'b0, endcap_z});
    zp  = (!mom_z[MOM_W-1] && mom_z != '0) ? zc : -zc;
    dz  = 22'(zp) - 22'(ref_z);
    sgn = dz[21] != mom_z[MOM_W-1];

    cls        = '0;
    cls.rx     = ref_x;
    cls.ry     = ref_y;
    cls.rz     = ref_z;
    cls.px     = mom_x;
    cls.py     = mom_y;
    cls.pz     = mom_z;
    cls.zp     = zp;
    cls.dzm    = dz[21] ? 22'(-dz) : 22'(dz);
    cls.negx   = sgn != mom_x[MOM_W-1];
    cls.negy   = sgn != mom_y[MOM_W-1];
    cls.region = RG_ENDCAP;
    if (mom_z == '0) begin
      cls.status = ST_PZ0;
    end else if (mag21(ref_z) > {1'b0, endcap_z}) begin
      cls.status = ST_BEYOND;
    end else begin
      cls.status = ST_OK;
    end
  end

  assign in_stall = fv && q_full;
  assign push     = fv && !q_full;
  assign item     = fitem;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (!in_stall) begin
      fv <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      fitem <= cls;
    end
  end

endmodule

`default_nettype wire

>>> sv/cee_queue.sv
// Short FIFO of classified tracks between the front and back ends.
// Depends on cee_pkg.
`default_nettype none

module cee_queue import cee_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  trk_t din,
  input  logic pop,
  output trk_t dout,
  output logic full,
  output logic empty
);

  trk_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wp;
  logic [QPTR_W-1:0] rp;
  logic [QPTR_W:0]   cnt;

  assign full  = cnt == (QPTR_W+1)'(QDEPTH);
  assign empty = cnt == '0;
  assign dout  = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= wp + 1'b1;
      end
      if (pop) begin
        rp <= rp + 1'b1;
      end
      cnt <= cnt + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= din;
    end
  end

endmodule

`default_nettype wire

>>> sv/cee_back.sv
// Back end: endcap projection, barrel decision, barrel quadratic, square
// root, final division and output register. Depends on cee_pkg, cee_div, cee_sqrt.
`default_nettype none

module cee_back import cee_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  trk_t                      head,
  input  logic                      q_empty,
  output logic                      pop,
  input  logic [CFG_W-1:0]          barrel_radius,
  input  logic                      out_stall,
  output logic                      out_valid,
  output logic signed [COORD_W-1:0] hit_x,
  output logic signed [COORD_W-1:0] hit_y,
  output logic signed [COORD_W-1:0] hit_z,
  output logic                      region,
  output logic [STAT_W-1:0]         status
);

  logic en;

  logic        v1;
  trk_t        t1;
  logic [45:0] n1x;
  logic [45:0] n1y;

  logic [DIV_QW-1:0]  qex;
  logic [DIV_QW-1:0]  qey;
  trk_t               da [DIV_LAT];
  logic [DIV_LAT-1:0] va;

  logic v2;
  trk_t t2;
  trk_t t2_n;

  logic               v3;
  trk_t               t3;
  logic [47:0]        sqhx, sqhy, sqpx, sqpy;
  logic [41:0]        sqrx, sqry;
  logic signed [44:0] prx, pry;
  logic [39:0]        rsq;

  logic        v4;
  trk_t        t4;
  trk_t        t4_n;
  logic [39:0] c4;
  logic [47:0] h2;
  logic [41:0] rr;

  logic        v5;
  trk_t        t5;
  logic [45:0] bm;
  logic [47:0] bll;
  logic [44:0] blh;
  logic [41:0] bhh;
  logic [47:0] acll;
  logic [39:0] aclh;
  logic [47:0] achl;
  logic [39:0] achh;

  logic           v6;
  trk_t           t6;
  logic [D_W-1:0] bsq;
  logic [D_W-1:0] acp;

  logic           v7;
  trk_t           t7;
  logic [D_W-1:0] dval;

  logic [SQ_W-1:0]   sroot;
  trk_t              db [SQ_LAT];
  logic [SQ_LAT-1:0] vb;

  logic               v8;
  trk_t               t8;
  logic [M_W-1:0]     mval;
  logic signed [63:0] md;

  logic        v9;
  trk_t        t9;
  logic [54:0] plx, phx, ply, phy, plz, phz;

  logic              v10;
  trk_t              t10;
  logic [DIV_NW-1:0] n10x, n10y, n10z;

  logic [DIV_QW-1:0]  qbx, qby, qbz;
  trk_t               dc [DIV_LAT];
  logic [DIV_LAT-1:0] vc;
  trk_t               tc;

  logic signed [COORD_W-1:0] hx_n, hy_n, hz_n;

  // The whole back end holds while a finished result waits to be taken.
  assign en  = !(out_valid && out_stall);
  assign pop = en && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; va <= '0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
      v6 <= 1'b0; v7 <= 1'b0; vb <= '0; v8 <= 1'b0; v9 <= 1'b0; v10 <= 1'b0;
      vc <= '0; out_valid <= 1'b0;
    end else if (en) begin
      v1        <= !q_empty;
      va        <= {va[DIV_LAT-2:0], v1};
      v2        <= va[DIV_LAT-1];
      v3        <= v2;
      v4        <= v3;
      v5        <= v4;
      v6        <= v5;
      v7        <= v6;
      vb        <= {vb[SQ_LAT-2:0], v7};
      v8        <= vb[SQ_LAT-1];
      v9        <= v8;
      v10       <= v9;
      vc        <= {vc[DIV_LAT-2:0], v10};
      out_valid <= vc[DIV_LAT-1];
    end
  end

  cee_div u_div_ex (
    .clk (clk),
    .en  (en),
    .num ({42'b0, n1x}),
    .den ({40'b0, mag24(t1.pz)}),
    .quo (qex)
  );

  cee_div u_div_ey (
    .clk (clk),
    .en  (en),
    .num ({42'b0, n1y}),
    .den ({40'b0, mag24(t1.pz)}),
    .quo (qey)
  );

  cee_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  ({dval, 32'b0}),
    .root (sroot)
  );

  cee_div u_div_bx (
    .clk (clk),
    .en  (en),
    .num (n10x),
    .den ({t10.a, 16'b0}),
    .quo (qbx)
  );

  cee_div u_div_by (
    .clk (clk),
    .en  (en),
    .num (n10y),
    .den ({t10.a, 16'b0}),
    .quo (qby)
  );

  cee_div u_div_bz (
    .clk (clk),
    .en  (en),
    .num (n10z),
    .den ({t10.a, 16'b0}),
    .quo (qbz)
  );

  // Endcap point from the first pair of quotients.
  always_comb begin
    t2_n    = da[DIV_LAT-1];
    t2_n.hx = offs(da[DIV_LAT-1].rx, da[DIV_LAT-1].negx, qex);
    t2_n.hy = offs(da[DIV_LAT-1].ry, da[DIV_LAT-1].negy, qey);
  end

  // Barrel decision and the special cases of the barrel path.
  always_comb begin
    h2         = sqhx + sqhy;
    rr         = sqrx + sqry;
    t4_n       = t3;
    t4_n.a     = sqpx + sqpy;
    t4_n.b     = 46'(prx) + 46'(pry);
    if (t3.status == ST_OK && h2 > 48'(rsq)) begin
      t4_n.region = RG_BARREL;
      if (t4_n.a == '0) begin
        t4_n.status = ST_PT0;
      end else if (rr > 42'(rsq)) begin
        t4_n.status = ST_OUTSIDE;
      end
    end
  end

  assign bm = mag46(t4.b);
  assign md = $signed({3'b0, sroot}) -
              $signed({{2{db[SQ_LAT-1].b[45]}}, db[SQ_LAT-1].b, 16'b0});
  assign tc = dc[DIV_LAT-1];

  always_comb begin
    if (tc.status != ST_OK) begin
      hx_n = '0;
      hy_n = '0;
      hz_n = '0;
    end else if (tc.region == RG_ENDCAP) begin
      hx_n = sat_coord(tc.hx);
      hy_n = sat_coord(tc.hy);
      hz_n = tc.zp;
    end else begin
      hx_n = sat_coord(offs(tc.rx, tc.px[MOM_W-1], qbx));
      hy_n = sat_coord(offs(tc.ry, tc.py[MOM_W-1], qby));
      hz_n = sat_coord(offs(tc.rz, tc.pz[MOM_W-1], qbz));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1  <= head;
      n1x <= 46'(mag24(head.px)) * 46'(head.dzm);
      n1y <= 46'(mag24(head.py)) * 46'(head.dzm);

      da[0] <= t1;
      for (int k = 1; k < DIV_LAT; k++) begin
        da[k] <= da[k-1];
      end

      t2 <= t2_n;

      t3   <= t2;
      sqhx <= 48'(mag24(t2.hx)) * 48'(mag24(t2.hx));
      sqhy <= 48'(mag24(t2.hy)) * 48'(mag24(t2.hy));
      sqpx <= 48'(mag24(t2.px)) * 48'(mag24(t2.px));
      sqpy <= 48'(mag24(t2.py)) * 48'(mag24(t2.py));
      sqrx <= 42'(mag21(t2.rx)) * 42'(mag21(t2.rx));
      sqry <= 42'(mag21(t2.ry)) * 42'(mag21(t2.ry));
      prx  <= 45'(t2.rx) * 45'(t2.px);
      pry  <= 45'(t2.ry) * 45'(t2.py);
      rsq  <= 40'(barrel_radius) * 40'(barrel_radius);

      t4 <= t4_n;
      c4 <= rsq - rr[39:0];

      // Both products of the discriminant are split into 24-bit pieces.
      t5   <= t4;
      bll  <= 48'(bm[23:0]) * 48'(bm[23:0]);
      blh  <= 45'(bm[23:0]) * 45'(bm[44:24]);
      bhh  <= 42'(bm[44:24]) * 42'(bm[44:24]);
      acll <= 48'(t4.a[23:0]) * 48'(c4[23:0]);
      aclh <= 40'(t4.a[23:0]) * 40'(c4[39:24]);
      achl <= 48'(t4.a[47:24]) * 48'(c4[23:0]);
      achh <= 40'(t4.a[47:24]) * 40'(c4[39:24]);

      t6  <= t5;
      bsq <= D_W'(bll) + (D_W'(blh) << 25) + (D_W'(bhh) << 48);
      acp <= D_W'(acll) + ((D_W'(aclh) + D_W'(achl)) << 24) + (D_W'(achh) << 48);

      t7   <= t6;
      dval <= bsq + acp;

      db[0] <= t7;
      for (int k = 1; k < SQ_LAT; k++) begin
        db[k] <= db[k-1];
      end

      t8   <= db[SQ_LAT-1];
      mval <= md[63] ? '0 : md[M_W-1:0];

      t9  <= t8;
      plx <= 55'(mag24(t8.px)) * 55'(mval[30:0]);
      phx <= 55'(mag24(t8.px)) * 55'(mval[61:31]);
      ply <= 55'(mag24(t8.py)) * 55'(mval[30:0]);
      phy <= 55'(mag24(t8.py)) * 55'(mval[61:31]);
      plz <= 55'(mag24(t8.pz)) * 55'(mval[30:0]);
      phz <= 55'(mag24(t8.pz)) * 55'(mval[61:31]);

      t10  <= t9;
      n10x <= (DIV_NW'(phx) << 31) + DIV_NW'(plx);
      n10y <= (DIV_NW'(phy) << 31) + DIV_NW'(ply);
      n10z <= (DIV_NW'(phz) << 31) + DIV_NW'(plz);

      dc[0] <= t10;
      for (int k = 1; k < DIV_LAT; k++) begin
        dc[k] <= dc[k-1];
      end

      hit_x  <= hx_n;
      hit_y  <= hy_n;
      hit_z  <= hz_n;
      region <= tc.region;
      status <= tc.status;
    end
  end

endmodule

`default_nettype wire

>>> sv/calorimeter_entry_extrapolation_unit.sv
// Throughput: one track per cycle while neither side stalls, set by the fully
// pipelined dividers (one quotient bit per stage) and square root (one root
// bit per stage). Reset is synchronous; it empties the pipeline and queue
// and loads endcap_z = 156800 and barrel_radius = 137600.
`default_nettype none

module calorimeter_entry_extrapolation_unit import cee_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [COORD_W-1:0] ref_x,
  input  logic signed [COORD_W-1:0] ref_y,
  input  logic signed [COORD_W-1:0] ref_z,
  input  logic signed [MOM_W-1:0]   mom_x,
  input  logic signed [MOM_W-1:0]   mom_y,
  input  logic signed [MOM_W-1:0]   mom_z,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [COORD_W-1:0] hit_x,
  output logic signed [COORD_W-1:0] hit_y,
  output logic signed [COORD_W-1:0] hit_z,
  output logic                      region,
  output logic [STAT_W-1:0]         status,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]          cfg_data
);

  logic [CFG_W-1:0] endcap_z;
  logic [CFG_W-1:0] barrel_radius;

  logic push;
  logic pop;
  logic q_full;
  logic q_empty;
  trk_t item;
  trk_t head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      endcap_z      <= ENDCAP_Z_RST;
      barrel_radius <= BARREL_R_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ENDCAP_Z: endcap_z      <= cfg_data;
        CFG_BARREL_R: barrel_radius <= cfg_data;
      endcase
    end
  end

  cee_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .ref_x    (ref_x),
    .ref_y    (ref_y),
    .ref_z    (ref_z),
    .mom_x    (mom_x),
    .mom_y    (mom_y),
    .mom_z    (mom_z),
    .endcap_z (endcap_z),
    .q_full   (q_full),
    .push     (push),
    .item     (item)
  );

  cee_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (item),
    .pop   (pop),
    .dout  (head),
    .full  (q_full),
    .empty (q_empty)
  );

  cee_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .q_empty       (q_empty),
    .pop           (pop),
    .barrel_radius (barrel_radius),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .hit_x         (hit_x),
    .hit_y         (hit_y),
    .hit_z         (hit_z),
    .region        (region),
    .status        (status)
  );

  // Any error result carries a zero point.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> hit_x == '0 && hit_y == '0 && hit_z == '0)
    else $error("error result with nonzero hit point");

  a_endcap_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_PZ0 || status == ST_BEYOND) |-> region == RG_ENDCAP)
    else $error("endcap-stage error reported in barrel region");

  a_barrel_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_PT0 || status == ST_OUTSIDE) |-> region == RG_BARREL)
    else $error("barrel-stage error reported in endcap region");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

endmodule

`default_nettype wire
